// File: hdl/assert_macros.svh
// assertion macros used by the rate limiter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWRL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWRL_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SWRL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWRL_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/swrl_pkg.sv
// shared types and constants of the sliding window rate limiter
package swrl_pkg;

    localparam int KEY_W  = 58;
    localparam int TIME_W = 32;
    localparam int CAP_W  = 5;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_MATCH,
        OP_PURGE,
        OP_APPEND,
        OP_ALLOC
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        key_t     key;
        time_t    now;
        time_t    limit;
        logic     limit_en;
    } cell_cmd_t;

endpackage

// File: hdl/sliding_window_rate_limiter.sv
// top level of the sliding window rate limiter
//  channel  | dir | payload
//  s_axis   | in  | tuser: action; tdata: cell_x, cell_y, cell_z, effect_id, now,
//           |     |        window_length, max_count
//  m_axis   | out | tdata: allowed; tuser: table_full
// a check on a known key steps through key match, scan, one purge step per log slot,
// append and output load. a new key or a full table steps through key match, scan and
// output load; a clear or a disabled check goes straight to the output load.
// the input reopens the cycle after the result is loaded; reset empties the table at once.
// a result waiting on m_axis holds the block in its last state until taken.
module sliding_window_rate_limiter #(
    parameter int ENTRIES  = 64,
    parameter int MAX_HITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cell_x, cell_y, cell_z, effect_id, now, window_length, max_count, pad
    input  logic [127:0] s_axis_tdata,
    // action
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // allowed, pad
    output logic [7:0]   m_axis_tdata,
    // table_full
    output logic         m_axis_tuser
);
    import swrl_pkg::*;

    `include "assert_macros.svh"

    localparam int CW = $clog2(MAX_HITS + 1);
    localparam int FW = $clog2(ENTRIES + 1);
    localparam int PW = $clog2(MAX_HITS + 1);
    localparam int SW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_SCAN,
        S_PURGE,
        S_APPEND,
        S_DONE
    } state_t;

    state_t          state_reg;
    key_t            key_reg;
    time_t           now_reg;
    time_t           limit_reg;
    logic            limit_en_reg;
    logic [CW-1:0]   cap_reg;
    logic [FW-1:0]   fill_reg;
    logic [PW-1:0]   step_reg;
    logic            res_allowed_reg;
    logic            res_full_reg;
    logic            out_valid_reg;
    logic            out_allowed_reg;
    logic            out_full_reg;

    logic            accept;
    logic            out_load;
    logic            in_action;
    key_t            in_key;
    time_t           in_now;
    time_t           in_window;
    logic [CAP_W-1:0] in_cap;
    logic [SW-1:0]   cap_wide;
    cell_cmd_t       cmd;
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] grant_vec;
    logic            hit_any;
    logic            table_room;

    // unpack the input beat
    assign in_action = s_axis_tuser;
    assign in_key    = s_axis_tdata[57:0];
    assign in_now    = s_axis_tdata[89:58];
    assign in_window = s_axis_tdata[121:90];
    assign in_cap    = s_axis_tdata[126:122];
    assign cap_wide  = SW'(in_cap);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign hit_any       = |hit_vec;
    assign table_room    = fill_reg < FW'(ENTRIES);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_allowed_reg};
    assign m_axis_tuser  = out_full_reg;

    // command broadcast to the row of entries
    always_comb
    begin
        cmd.key      = key_reg;
        cmd.now      = now_reg;
        cmd.limit    = limit_reg;
        cmd.limit_en = limit_en_reg;
        case (state_reg)
            S_IDLE:   cmd.op = (accept && in_action) ? OP_CLEAR : OP_NOP;
            S_MATCH:  cmd.op = OP_MATCH;
            S_SCAN:   cmd.op = (!hit_any && table_room) ? OP_ALLOC : OP_NOP;
            S_PURGE:  cmd.op = OP_PURGE;
            S_APPEND: cmd.op = OP_APPEND;
            default:  cmd.op = OP_NOP;
        endcase
    end

    // row of entries
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        swrl_cell #(
            .MAX_HITS(MAX_HITS),
            .CW      (CW)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .cmd  (cmd),
            .sel  (fill_reg == FW'(i)),
            .cap  (cap_reg),
            .hit  (hit_vec[i]),
            .grant(grant_vec[i])
        );
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg      <= in_key;
            now_reg      <= in_now;
            limit_reg    <= in_now - in_window;
            limit_en_reg <= in_now >= in_window;
            cap_reg      <= (cap_wide > SW'(MAX_HITS)) ? CW'(MAX_HITS) : CW'(cap_wide);
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            step_reg        <= '0;
            res_allowed_reg <= 1'b0;
            res_full_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_allowed_reg <= 1'b0;
            out_full_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_full_reg <= 1'b0;
                        if (in_action)
                        begin
                            fill_reg        <= '0;
                            res_allowed_reg <= 1'b0;
                            state_reg       <= S_DONE;
                        end
                        else if (in_window == '0 || in_cap == '0)
                        begin
                            res_allowed_reg <= 1'b1;
                            state_reg       <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_MATCH;
                        end
                    end
                end
                S_MATCH:  state_reg <= S_SCAN;
                S_SCAN:
                begin
                    step_reg <= '0;
                    if (hit_any)
                    begin
                        state_reg <= S_PURGE;
                    end
                    else
                    begin
                        res_allowed_reg <= 1'b1;
                        res_full_reg    <= !table_room;
                        if (table_room)
                            fill_reg <= fill_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_PURGE:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == PW'(MAX_HITS - 1))
                        state_reg <= S_APPEND;
                end
                S_APPEND:
                begin
                    res_allowed_reg <= |grant_vec;
                    state_reg       <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_allowed_reg <= res_allowed_reg;
                        out_full_reg    <= res_full_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    `SWRL_ASSERT(a_one_hit, clk, rst_n, $onehot0(hit_vec), "more than one entry holds the key")
    `SWRL_ASSERT(a_fill_range, clk, rst_n, fill_reg <= FW'(ENTRIES), "fill count past table size")
    `SWRL_ASSERT(a_clear_fill, clk, rst_n, (accept && in_action) |=> (fill_reg == '0), "clear left entries")
    `SWRL_NEVER(a_grant_idle, clk, rst_n, (|grant_vec) && (state_reg != S_APPEND), "append outside its step")

endmodule

// File: hdl/swrl_cell.sv
// one table entry: key, count and a shifting log of timestamps
module swrl_cell #(
    parameter int MAX_HITS = 16,
    parameter int CW       = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swrl_pkg::cell_cmd_t cmd,
    input  logic                sel,
    input  logic [CW-1:0]       cap,
    output logic                hit,
    output logic                grant
);
    import swrl_pkg::*;

    logic                  valid_reg;
    key_t                  key_reg;
    logic [CW-1:0]         count_reg;
    time_t                 log_reg [MAX_HITS];
    logic                  hit_reg;
    logic                  stale;
    logic                  room;

    // head of the log is old enough to drop
    assign stale = (count_reg != '0) && cmd.limit_en && (log_reg[0] <= cmd.limit);
    assign room  = count_reg < cap;
    assign hit   = hit_reg;
    assign grant = hit_reg && (cmd.op == OP_APPEND) && room;

    // control state of the entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_CLEAR:
                begin
                    valid_reg <= 1'b0;
                    count_reg <= '0;
                    hit_reg   <= 1'b0;
                end
                OP_MATCH:  hit_reg <= valid_reg && (key_reg == cmd.key);
                OP_PURGE:
                begin
                    if (hit_reg && stale)
                        count_reg <= count_reg - 1'b1;
                end
                OP_APPEND:
                begin
                    if (grant)
                        count_reg <= count_reg + 1'b1;
                end
                OP_ALLOC:
                begin
                    if (sel)
                    begin
                        valid_reg <= 1'b1;
                        count_reg <= CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // key and timestamp log, each slot but the last takes its upper neighbor's value on a drop
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ALLOC && sel)
        begin
            key_reg    <= cmd.key;
            log_reg[0] <= cmd.now;
        end
        for (int k = 0; k < MAX_HITS; k++)
        begin
            if (cmd.op == OP_PURGE && hit_reg && stale)
            begin
                if (k < MAX_HITS - 1)
                    log_reg[k] <= log_reg[(k + 1) % MAX_HITS];
            end
            else if (grant && count_reg == CW'(k))
            begin
                log_reg[k] <= cmd.now;
            end
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// testbench of the sliding window rate limiter: directed table, then random checks
`timescale 1ns / 100ps

module tb_top;
    import swrl_pkg::*;

    localparam int N_ENTRIES = 64;
    localparam int N_HITS    = 16;
    localparam int N_RANDOM  = 420;
    localparam int MAX_CYCLES = 400000;

    typedef struct {
        logic              clear;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [9:0]        effect;
        logic [31:0]       now;
        logic [31:0]       window;
        logic [4:0]        cap;
    } event_t;

    typedef struct {
        logic allowed;
        logic full;
    } verdict_t;

    // directed row: the event plus an optional typed-in verdict
    typedef struct {
        event_t   ev;
        logic     typed;
        verdict_t verdict;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tuser;

    // limiter image kept by the testbench
    logic        log_valid [N_ENTRIES];
    logic [57:0] log_key   [N_ENTRIES];
    int          log_count [N_ENTRIES];
    logic [31:0] log_times [N_ENTRIES][N_HITS];

    verdict_t pending_verdicts[$];
    int       mismatches = 0;
    int       cycles = 0;
    int       send_gap_pct;
    int       recv_stall_pct;

    sliding_window_rate_limiter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("FAIL sliding_window_rate_limiter");
            $finish;
        end
    end

    function automatic void wipe_image();
        for (int s = 0; s < N_ENTRIES; s++)
        begin
            log_valid[s] = 1'b0;
            log_count[s] = 0;
        end
    endfunction

    // applies one event to the image and returns the verdict it earns
    function automatic verdict_t limit_event(event_t ev);
        verdict_t    v;
        logic [57:0] k;
        logic [31:0] thr;
        int          cap_eff;
        int          slot;
        int          n;
        int          drop;
        v.allowed = 1'b0;
        v.full = 1'b0;
        if (ev.clear)
        begin
            wipe_image();
            return v;
        end
        if (ev.window == 0 || ev.cap == 0)
        begin
            v.allowed = 1'b1;
            return v;
        end
        cap_eff = (ev.cap > N_HITS) ? N_HITS : int'(ev.cap);
        k = {ev.x, ev.y, ev.z, ev.effect};
        slot = -1;
        for (int s = 0; s < N_ENTRIES; s++)
            if (slot < 0 && log_valid[s] && log_key[s] == k)
                slot = s;
        if (slot >= 0)
        begin
            n = log_count[slot];
            drop = 0;
            // threshold does not wrap when now is below the window
            if (ev.now >= ev.window)
            begin
                thr = ev.now - ev.window;
                while (drop < n && log_times[slot][drop] <= thr)
                    drop++;
            end
            for (int j = drop; j < n; j++)
                log_times[slot][j - drop] = log_times[slot][j];
            n = n - drop;
            log_count[slot] = n;
            if (n >= cap_eff)
                return v;
            log_times[slot][n] = ev.now;
            log_count[slot] = n + 1;
            v.allowed = 1'b1;
            return v;
        end
        // new key takes the lowest free entry
        for (int s = 0; s < N_ENTRIES; s++)
        begin
            if (!log_valid[s])
            begin
                log_valid[s] = 1'b1;
                log_key[s] = k;
                log_count[s] = 1;
                log_times[s][0] = ev.now;
                v.allowed = 1'b1;
                return v;
            end
        end
        v.allowed = 1'b1;
        v.full = 1'b1;
        return v;
    endfunction

    // drives one beat and waits for its acceptance
    task automatic send_event(event_t ev, logic typed, verdict_t typed_v);
        verdict_t v;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev.clear;
        s_axis_tdata  <= {1'b0, ev.cap, ev.window, ev.now, ev.effect, ev.z, ev.y, ev.x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        v = limit_event(ev);
        if (typed)
            v = typed_v;
        pending_verdicts.push_back(v);
    endtask

    function automatic event_t mk(int c, int x, int y, int z, int e,
                                  logic [31:0] t, logic [31:0] w, int cap);
        event_t ev;
        ev.clear = (c != 0);
        ev.x = 16'(x);
        ev.y = 16'(y);
        ev.z = 16'(z);
        ev.effect = 10'(e);
        ev.now = t;
        ev.window = w;
        ev.cap = 5'(cap);
        return ev;
    endfunction

    // result checker and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: allowed %0b table_full %0b",
                                 m_axis_tdata[0], m_axis_tuser);
                end
                else
                begin
                    verdict_t v;
                    v = pending_verdicts.pop_front();
                    if (v.allowed !== m_axis_tdata[0] || v.full !== m_axis_tuser
                        || m_axis_tdata[7:1] !== 7'd0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected allowed %0b table_full %0b, got %0b %0b",
                                     v.allowed, v.full, m_axis_tdata[0], m_axis_tuser);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        row_t        rows[$];
        row_t        r;
        verdict_t    ok;
        verdict_t    none;
        verdict_t    dummy;
        event_t      ev;
        event_t      pool[6];
        logic [31:0] clock_ticks;
        int          waited;
        ok.allowed = 1'b1;
        ok.full = 1'b0;
        none.allowed = 1'b0;
        none.full = 1'b0;
        dummy = none;
        send_gap_pct = 9;
        recv_stall_pct = 70;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        wipe_image();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        rows.push_back('{mk(0, -32768, 32767, 0, 1023, 100, 50, 2), 1'b1, ok});
        rows.push_back('{mk(0, -32768, 32767, 0, 1023, 110, 50, 2), 1'b0, none});
        rows.push_back('{mk(0, -32768, 32767, 0, 1023, 120, 50, 2), 1'b0, none});
        rows.push_back('{mk(0, -32768, 32767, 0, 1023, 160, 50, 2), 1'b0, none});
        rows.push_back('{mk(0, 5, 5, 5, 5, 200, 0, 3), 1'b1, ok});
        rows.push_back('{mk(0, 5, 5, 5, 5, 32'hFFFF_FFFF, 10, 0), 1'b1, ok});
        rows.push_back('{mk(0, 1, 2, 3, 4, 5, 1000, 1), 1'b1, ok});
        rows.push_back('{mk(0, 1, 2, 3, 4, 6, 1000, 1), 1'b0, none});
        rows.push_back('{mk(0, 1, 2, 3, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16), 1'b0, none});
        rows.push_back('{mk(0, 32767, -32768, -1, 0, 7, 32'hFFFF_FFFF, 16), 1'b1, ok});
        for (int i = 0; i < 17; i++)
            rows.push_back('{mk(0, 32767, -32768, -1, 0, 8 + i, 32'hFFFF_FFFF, 16),
                             1'b0, none});
        rows.push_back('{mk(0, 9, 9, 9, 9, 1000, 100, 4), 1'b1, ok});
        rows.push_back('{mk(0, 9, 9, 9, 9, 900, 100, 4), 1'b0, none});
        rows.push_back('{mk(0, 9, 9, 9, 9, 1050, 100, 4), 1'b0, none});
        rows.push_back('{mk(0, 9, 9, 9, 9, 1101, 100, 4), 1'b0, none});
        rows.push_back('{mk(1, -1, -1, -1, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16),
                         1'b1, none});
        rows.push_back('{mk(0, -32768, 32767, 0, 1023, 170, 50, 2), 1'b1, ok});
        foreach (rows[i])
            send_event(rows[i].ev, rows[i].typed, rows[i].verdict);

        // random part: a few hot keys, noise, clears and one table fill
        for (int p = 0; p < 6; p++)
            pool[p] = mk(0, $urandom, $urandom, $urandom, $urandom_range(0, 1023), 0, 0, 0);
        clock_ticks = $urandom;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                send_gap_pct = 70;
                recv_stall_pct = 9;
            end
            else if (i == 2 * N_RANDOM / 3)
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            clock_ticks = clock_ticks + $urandom_range(0, 20);
            if (i == 200 || $urandom_range(0, 59) == 0)
            begin
                ev = mk(1, $urandom, $urandom, $urandom, $urandom_range(0, 1023),
                        $urandom, $urandom, $urandom_range(0, 16));
            end
            else if (i > 200 && i <= 270)
            begin
                // distinct keys until the table overflows
                ev = mk(0, i, 16'h7000, i, i, clock_ticks, 100, 3);
            end
            else if ($urandom_range(0, 99) < 80)
            begin
                ev = pool[$urandom_range(0, 5)];
                ev.now = clock_ticks;
                ev.window = $urandom_range(1, 60);
                ev.cap = ($urandom_range(0, 9) == 0) ? 5'd16 : 5'($urandom_range(1, 5));
            end
            else
            begin
                ev = mk(0, $urandom, $urandom, $urandom, $urandom_range(0, 1023),
                        $urandom, $urandom, $urandom_range(0, 16));
            end
            send_event(ev, 1'b0, dummy);
        end
        s_axis_tvalid <= 1'b0;

        // drain
        waited = 0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        while (waited < 60)
        begin
            @(posedge clk);
            waited++;
        end
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("PASS sliding_window_rate_limiter");
        else
            $display("FAIL sliding_window_rate_limiter");
        $finish;
    end

endmodule
